[rtl/core/ikf_pkg.sv]
// Shared types, constants and helper functions for the IMU Kalman orientation core.
// Used by every module in rtl/core except ikf_checker; depends on nothing.
package ikf_pkg;

  // CORDIC iteration count and derived counter width
  localparam int CORDIC_STEPS = 24;
  localparam int CNT_W        = $clog2(CORDIC_STEPS);

  // datapath widths
  localparam int CW     = 40;  // CORDIC x/y
  localparam int ZW     = 36;  // CORDIC angle, Q.30 radians
  localparam int MA_W   = 38;  // multiplier operand a
  localparam int MB_W   = 32;  // multiplier operand b
  localparam int MP_W   = MA_W + MB_W;
  localparam int MR_W   = 41;  // rounded product
  localparam int NUM_W  = 62;  // divider numerator magnitude
  localparam int DEN_W  = 33;  // divider denominator
  localparam int QCNT_W = $clog2(NUM_W);

  // fixed constants
  localparam logic signed [ZW-1:0]   PI_Q30      = 36'sd3373259426;
  localparam logic signed [MB_W-1:0] INVK_Q30    = 32'sd652032874;
  localparam logic signed [MB_W-1:0] RAD2DEG_Q24 = 32'sd961263669;

  // register reset values and indexes
  localparam logic [29:0] QA_RESET = 30'd1073742;
  localparam logic [29:0] QB_RESET = 30'd3221225;
  localparam logic [29:0] R_RESET  = 30'd21474836;
  localparam logic [29:0] DT_RESET = 30'd10737418;

  localparam logic [2:0] REG_QA = 3'd0;
  localparam logic [2:0] REG_QB = 3'd1;
  localparam logic [2:0] REG_R  = 3'd2;
  localparam logic [2:0] REG_DT = 3'd3;

  // micro-operations of one sample
  typedef enum logic [4:0] {
    OP_PRED0 = 5'd0,  OP_PRED1 = 5'd1,  OP_PRED2 = 5'd2,
    OP_P11DT = 5'd3,  OP_TDT   = 5'd4,  OP_QBDT  = 5'd5,
    OP_CORM1 = 5'd6,  OP_MAG1  = 5'd7,  OP_CORA0 = 5'd8,  OP_DEG0 = 5'd9,
    OP_CORM2 = 5'd10, OP_MAG2  = 5'd11, OP_CORA1 = 5'd12, OP_DEG1 = 5'd13,
    OP_CORA2 = 5'd14, OP_DEG2  = 5'd15,
    OP_DIV0  = 5'd16, OP_DIV1  = 5'd17,
    OP_C10   = 5'd18, OP_C11   = 5'd19, OP_C00   = 5'd20, OP_C01  = 5'd21,
    OP_UPB0  = 5'd22, OP_UPB1  = 5'd23, OP_UPB2  = 5'd24,
    OP_UPA0  = 5'd25, OP_UPA1  = 5'd26, OP_UPA2  = 5'd27
  } op_t;

  typedef enum logic [1:0] {
    KIND_MUL = 2'd0,
    KIND_COR = 2'd1,
    KIND_DIV = 2'd2
  } kind_t;

  // requests to the shared units
  typedef struct packed {
    logic                 start;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } cord_req_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  function automatic kind_t op_kind(input op_t op);
    kind_t k;
    case (op)
      OP_CORM1, OP_CORA0, OP_CORM2, OP_CORA1, OP_CORA2: k = KIND_COR;
      OP_DIV0, OP_DIV1:                                 k = KIND_DIV;
      default:                                          k = KIND_MUL;
    endcase
    return k;
  endfunction

  // atan(2^-i) in Q.30, exact powers of two from step 10 on
  function automatic logic [31:0] atan_entry(input logic [CNT_W-1:0] i);
    int ii;
    logic [31:0] v;
    ii = int'(i);
    case (ii)
      0: v = 32'd843314857;
      1: v = 32'd497837829;
      2: v = 32'd263043837;
      3: v = 32'd133525159;
      4: v = 32'd67021687;
      5: v = 32'd33543516;
      6: v = 32'd16775851;
      7: v = 32'd8388437;
      8: v = 32'd4194283;
      9: v = 32'd2097149;
      default: v = (ii <= 30) ? (32'd1 << (30 - ii)) : 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647)       r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

[rtl/core/ikf_mul.sv]
// Shared signed multiplier with registered product and round-half-up rescale.
// Depends on ikf_pkg.
module ikf_mul
  import ikf_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [MA_W-1:0] a,
  input  logic signed [MB_W-1:0] b,
  input  logic                   long_shift,
  output logic signed [MR_W-1:0] res
);

  logic signed [MP_W-1:0] prod;
  logic                   long_q;
  logic signed [MP_W-1:0] sum;
  logic signed [MP_W-1:0] shifted;

  // product register
  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= a * b;
      long_q <= long_shift;
    end
  end

  // round half up, then shift by 38 (degrees) or 30
  always_comb begin
    sum     = prod + (long_q ? (MP_W'(1) <<< 37) : (MP_W'(1) <<< 29));
    shifted = long_q ? (sum >>> 38) : (sum >>> 30);
    res     = shifted[MR_W-1:0];
  end

endmodule

[rtl/core/ikf_cordic.sv]
// Iterative vectoring CORDIC: angle in Q.30 radians and raw magnitude, one step a cycle.
// Depends on ikf_pkg.
module ikf_cordic
  import ikf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cord_req_t            req,
  output logic signed [CW-1:0] x_res,
  output logic signed [ZW-1:0] z_res,
  output logic                 done
);

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] ae;

  // one micro-rotation
  always_comb begin
    dx = y >>> cnt;
    dy = x >>> cnt;
    ae = ZW'(atan_entry(cnt));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= '0;
        if (req.x == '0 && req.y == '0) begin
          x    <= '0;
          y    <= '0;
          z    <= '0;
          done <= 1'b1;
        end else if (req.x < 0) begin
          // pre-rotate by 180 degrees
          x    <= -req.x;
          y    <= -req.y;
          z    <= (req.y >= 0) ? PI_Q30 : -PI_Q30;
          busy <= 1'b1;
        end else begin
          x    <= req.x;
          y    <= req.y;
          z    <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + ae;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - ae;
        end
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  assign x_res = x;
  assign z_res = z;

endmodule

[rtl/core/ikf_div.sv]
// Restoring unsigned divider, one quotient bit a cycle.
// Depends on ikf_pkg.
module ikf_div
  import ikf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  q;
  logic [QCNT_W-1:0] cnt;
  logic              busy;
  logic [DEN_W:0]    rem_sh;
  logic              fits;

  // trial subtract
  always_comb begin
    rem_sh = {rem, q[NUM_W-1]};
    fits   = (rem_sh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        den  <= req.den;
        rem  <= '0;
        q    <= req.num;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
        q   <= {q[NUM_W-2:0], fits};
        if (cnt == QCNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  assign quo = q;

endmodule

[rtl/core/imu_kalman_orientation_core.sv]
// IMU orientation Kalman filter: roll/pitch/yaw with gyro bias tracking.
// Each sample runs from the input transfer to a valid result through five CORDIC passes,
// up to two gain divisions and 21 multiplies on the shared units; in_stall is high from
// accept until the result is queued, so a new sample is not taken before then.
// Reset (rst, synchronous): angles, biases and covariance cleared, registers to defaults.
// Depends on ikf_pkg, ikf_mul, ikf_cordic, ikf_div.
module imu_kalman_orientation_core
  import ikf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] rate_x,
  input  logic signed [31:0] rate_y,
  input  logic signed [31:0] rate_z,
  input  logic signed [31:0] acc_x,
  input  logic signed [31:0] acc_y,
  input  logic signed [31:0] acc_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] roll_out,
  output logic signed [31:0] pitch_out,
  output logic signed [31:0] yaw_out,
  output logic signed [31:0] bias_x_out,
  output logic signed [31:0] bias_y_out,
  output logic signed [31:0] bias_z_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [29:0]        cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t state;
  op_t    op;
  kind_t  kind;

  logic [29:0] qa, qb, r, dt;
  logic signed [31:0] rin [3];
  logic signed [31:0] ax, ay, az;
  logic signed [31:0] ang [3];
  logic signed [31:0] bias [3];
  logic signed [31:0] p00, p01, p10, p11;
  logic signed [32:0] p11dt;
  logic signed [33:0] mag;
  logic signed [32:0] meas [3];
  logic signed [31:0] k0, k1;

  logic signed [32:0] rate [3];
  logic signed [33:0] innov [3];
  logic signed [34:0] t;
  logic signed [33:0] s;
  logic               s_pos;
  logic signed [31:0] dnum;
  logic [31:0]        num_abs;

  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic                   mlong;
  logic                   mul_en;
  logic signed [MR_W-1:0] mres;
  logic signed [63:0]     mr64;

  cord_req_t            creq;
  logic signed [CW-1:0] cx;
  logic signed [ZW-1:0] cz;
  logic                 cdone;

  div_req_t         dreq;
  logic [NUM_W-1:0] dq;
  logic             ddone;
  logic signed [63:0] dqs;
  logic signed [31:0] ksat;

  logic unit_done;
  logic out_free;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign kind      = op_kind(op);
  assign out_free  = !out_valid || !out_stall;

  // per-axis terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rate[i]  = 33'(rin[i]) - 33'(bias[i]);
      innov[i] = 34'(meas[i]) - 34'(ang[i]);
    end
    t       = 35'(p10) + 35'(p01) - 35'(p11dt) - 35'({1'b0, qa});
    s       = 34'(p00) + 34'({1'b0, r});
    s_pos   = !s[33] && (s != '0);
    // k0 divides P00, k1 divides P10
    dnum    = (op == OP_DIV1) ? p10 : p00;
    num_abs = dnum[31] ? 32'(-dnum) : 32'(dnum);
    mr64    = 64'(mres);
    dqs     = 64'({2'b00, dq});
    ksat    = sat32(dnum[31] ? -dqs : dqs);
  end

  // operand selection for the shared units
  always_comb begin
    ma         = '0;
    mb         = '0;
    mlong      = 1'b0;
    creq.start = (state == ST_ISSUE) && (kind == KIND_COR);
    creq.x     = '0;
    creq.y     = '0;
    case (op)
      OP_PRED0: begin ma = MA_W'(rate[0]); mb = MB_W'({2'b00, dt}); end
      OP_PRED1: begin ma = MA_W'(rate[1]); mb = MB_W'({2'b00, dt}); end
      OP_PRED2: begin ma = MA_W'(rate[2]); mb = MB_W'({2'b00, dt}); end
      OP_P11DT: begin ma = MA_W'(p11); mb = MB_W'({2'b00, dt}); end
      OP_TDT:   begin ma = MA_W'(t); mb = MB_W'({2'b00, dt}); end
      OP_QBDT:  begin ma = MA_W'({1'b0, qb}); mb = MB_W'({2'b00, dt}); end
      OP_CORM1: begin creq.x = CW'(ax); creq.y = CW'(az); end
      OP_CORA0: begin creq.x = CW'(mag); creq.y = CW'(ay); end
      OP_CORM2: begin creq.x = CW'(ay); creq.y = CW'(az); end
      OP_CORA1: begin creq.x = CW'(mag); creq.y = CW'(ax); end
      OP_CORA2: begin creq.x = CW'(ax); creq.y = CW'(ay); end
      OP_MAG1, OP_MAG2: begin ma = cx[MA_W-1:0]; mb = INVK_Q30; end
      OP_DEG0, OP_DEG1, OP_DEG2: begin
        ma = MA_W'(cz); mb = RAD2DEG_Q24; mlong = 1'b1;
      end
      OP_C10:  begin ma = MA_W'(p00); mb = k1; end
      OP_C11:  begin ma = MA_W'(p01); mb = k1; end
      OP_C00:  begin ma = MA_W'(p00); mb = k0; end
      OP_C01:  begin ma = MA_W'(p01); mb = k0; end
      OP_UPB0: begin ma = MA_W'(innov[0]); mb = k1; end
      OP_UPB1: begin ma = MA_W'(innov[1]); mb = k1; end
      OP_UPB2: begin ma = MA_W'(innov[2]); mb = k1; end
      OP_UPA0: begin ma = MA_W'(innov[0]); mb = k0; end
      OP_UPA1: begin ma = MA_W'(innov[1]); mb = k0; end
      OP_UPA2: begin ma = MA_W'(innov[2]); mb = k0; end
      default: begin ma = '0; end
    endcase
  end

  // unit starts
  assign mul_en     = (state == ST_ISSUE) && (kind == KIND_MUL);
  assign dreq.start = (state == ST_ISSUE) && (kind == KIND_DIV) && s_pos;
  assign dreq.num   = {num_abs, 30'd0};
  assign dreq.den   = s[DEN_W-1:0];

  always_comb begin
    case (kind)
      KIND_COR: unit_done = cdone;
      KIND_DIV: unit_done = ddone;
      default:  unit_done = 1'b1;
    endcase
  end

  ikf_mul u_mul (
    .clk        (clk),
    .en         (mul_en),
    .a          (ma),
    .b          (mb),
    .long_shift (mlong),
    .res        (mres)
  );

  ikf_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .req   (creq),
    .x_res (cx),
    .z_res (cz),
    .done  (cdone)
  );

  ikf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .quo  (dq),
    .done (ddone)
  );

  // result valid: set when the result is queued, cleared on an output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer, filter state and writeback
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_PRED0;
      qa        <= QA_RESET;
      qb        <= QB_RESET;
      r         <= R_RESET;
      dt        <= DT_RESET;
      for (int i = 0; i < 3; i++) begin
        ang[i]  <= '0;
        bias[i] <= '0;
      end
      p00 <= '0;
      p01 <= '0;
      p10 <= '0;
      p11 <= '0;
    end else begin
      // configuration transfer
      if (cfg_valid) begin
        case (cfg_index)
          REG_QA:  qa <= cfg_data;
          REG_QB:  qb <= cfg_data;
          REG_R:   r  <= cfg_data;
          REG_DT:  dt <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            rin[0] <= rate_x;
            rin[1] <= rate_y;
            rin[2] <= rate_z;
            ax     <= acc_x;
            ay     <= acc_y;
            az     <= acc_z;
            op     <= OP_PRED0;
            state  <= ST_ISSUE;
          end
        end

        ST_ISSUE: begin
          if (kind == KIND_DIV && !s_pos) begin
            // degenerate innovation variance: zero gain
            if (op == OP_DIV0) k0 <= '0;
            else               k1 <= '0;
            op <= op_t'(op + 5'd1);
          end else begin
            state <= ST_WAIT;
          end
        end

        ST_WAIT: begin
          if (unit_done) begin
            case (op)
              OP_PRED0: ang[0] <= sat32(64'(ang[0]) + mr64);
              OP_PRED1: ang[1] <= sat32(64'(ang[1]) + mr64);
              OP_PRED2: ang[2] <= sat32(64'(ang[2]) + mr64);
              OP_P11DT: p11dt  <= mres[32:0];
              OP_TDT: begin
                p00 <= sat32(64'(p00) - mr64);
                p01 <= sat32(64'(p01) - 64'(p11dt));
                p10 <= sat32(64'(p10) - 64'(p11dt));
              end
              OP_QBDT: p11 <= sat32(64'(p11) + mr64);
              OP_MAG1, OP_MAG2: mag <= mres[33:0];
              OP_DEG0: meas[0] <= mres[32:0];
              OP_DEG1: meas[1] <= mres[32:0];
              OP_DEG2: meas[2] <= mres[32:0];
              OP_DIV0: k0 <= ksat;
              OP_DIV1: k1 <= ksat;
              OP_C10:  p10 <= sat32(64'(p10) - mr64);
              OP_C11:  p11 <= sat32(64'(p11) - mr64);
              OP_C00:  p00 <= sat32(64'(p00) - mr64);
              OP_C01:  p01 <= sat32(64'(p01) - mr64);
              OP_UPB0: bias[0] <= sat32(64'(bias[0]) + mr64);
              OP_UPB1: bias[1] <= sat32(64'(bias[1]) + mr64);
              OP_UPB2: bias[2] <= sat32(64'(bias[2]) + mr64);
              OP_UPA0: ang[0]  <= sat32(64'(ang[0]) + mr64);
              OP_UPA1: ang[1]  <= sat32(64'(ang[1]) + mr64);
              OP_UPA2: ang[2]  <= sat32(64'(ang[2]) + mr64);
              default: ;
            endcase
            if (op == OP_UPA2) begin
              state <= ST_FIN;
            end else begin
              op    <= op_t'(op + 5'd1);
              state <= ST_ISSUE;
            end
          end
        end

        ST_FIN: begin
          // queue the result once the output register is free
          if (out_free) begin
            roll_out   <= ang[0];
            pitch_out  <= ang[1];
            yaw_out    <= ang[2];
            bias_x_out <= bias[0];
            bias_y_out <= bias[1];
            bias_z_out <= bias[2];
            state      <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/ikf_checker.sv]
// Port-level checker for imu_kalman_orientation_core, bound to the top level.
// Depends only on the top-level ports.
module ikf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [31:0] rate_x,
  input logic signed [31:0] rate_y,
  input logic signed [31:0] rate_z,
  input logic signed [31:0] acc_x,
  input logic signed [31:0] acc_y,
  input logic signed [31:0] acc_z,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] roll_out,
  input logic signed [31:0] pitch_out,
  input logic signed [31:0] yaw_out,
  input logic signed [31:0] bias_x_out,
  input logic signed [31:0] bias_y_out,
  input logic signed [31:0] bias_z_out,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [29:0]        cfg_data
);

  // an accepted sample makes the core busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("core not busy after input transfer");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(roll_out) && $stable(bias_z_out))
    else $error("stalled result changed");

  // a new result only appears from a busy core
  a_out_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // reset clears the output channel and frees the input
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset did not clear channels");

endmodule

bind imu_kalman_orientation_core ikf_checker u_ikf_checker (.*);

[tb/sv/imu_kalman_orientation_checker.sv]
// Checker for imu_kalman_orientation_core: predicts each result on input transfers
// and compares it with output transfers. Depends on ikf_pkg for constants.
`timescale 1ns / 1ps

module imu_kalman_orientation_checker
  import ikf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] rate_x,
  input  logic signed [31:0] rate_y,
  input  logic signed [31:0] rate_z,
  input  logic signed [31:0] acc_x,
  input  logic signed [31:0] acc_y,
  input  logic signed [31:0] acc_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] roll_out,
  input  logic signed [31:0] pitch_out,
  input  logic signed [31:0] yaw_out,
  input  logic signed [31:0] bias_x_out,
  input  logic signed [31:0] bias_y_out,
  input  logic signed [31:0] bias_z_out,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [29:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef logic signed [5:0][31:0] attitude_t;

  // filter state mirrored from the block
  longint angle_est[3];
  longint bias_est[3];
  longint cov[4];
  longint noise_qa, noise_qb, noise_r, dt_q30;

  attitude_t attitude_q[$];

  string field_name[6] = '{"roll_out", "pitch_out", "yaw_out",
                           "bias_x_out", "bias_y_out", "bias_z_out"};

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // product brought back to target format, rounded half up
  function automatic longint mul_rnd(input longint a, input longint b, input int sh);
    return (a * b + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint arctan_step(input int i);
    longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return head[i];
    if (i <= 30) return 64'sd1 <<< (30 - i);
    return 0;
  endfunction

  // vectoring CORDIC: angle in Q.30 radians and gain-corrected magnitude
  task automatic vector_cordic(input longint xi, input longint yi,
                               output longint ang, output longint mag);
    longint x, y, z, dx, dy;
    int i;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) begin
      ang = 0;
      mag = 0;
      return;
    end
    // left half plane: rotate by 180 degrees first
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      x = -x;
      y = -y;
    end
    for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_step(i);
      end else begin
        x -= dx; y += dy; z -= arctan_step(i);
      end
    end
    ang = z;
    mag = mul_rnd(x, longint'(INVK_Q30), 30);
  endtask

  task automatic tilt_deg(input longint y, input longint x, output longint deg);
    longint ang, mag;
    vector_cordic(x, y, ang, mag);
    deg = (ang * longint'(RAD2DEG_Q24) + (64'sd1 <<< 37)) >>> 38;
  endtask

  task automatic norm2(input longint a, input longint b, output longint mag);
    longint ang;
    vector_cordic(a, b, ang, mag);
  endtask

  // one filter step: predict, measure, update
  task automatic predict_attitude(input longint rate[3], input longint acc[3],
                                  output attitude_t res);
    longint meas[3], p00, p01, p10, p11, p11dt, t, s, k0, k1, mag, innov, t00, t01;
    int a;
    for (a = 0; a < 3; a++)
      angle_est[a] = clip32(angle_est[a] + mul_rnd(rate[a] - bias_est[a], dt_q30, 30));

    p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
    p11dt = mul_rnd(p11, dt_q30, 30);
    t = p10 + p01 - p11dt - noise_qa;
    p00 = clip32(p00 - mul_rnd(t, dt_q30, 30));
    p01 = clip32(p01 - p11dt);
    p10 = clip32(p10 - p11dt);
    p11 = clip32(p11 + mul_rnd(noise_qb, dt_q30, 30));

    norm2(acc[0], acc[2], mag);
    tilt_deg(acc[1], mag, meas[0]);
    norm2(acc[1], acc[2], mag);
    tilt_deg(acc[0], mag, meas[1]);
    tilt_deg(acc[1], acc[0], meas[2]);

    // degenerate innovation variance gives zero gains
    s = p00 + noise_r;
    if (s <= 0) begin
      k0 = 0;
      k1 = 0;
    end else begin
      k0 = clip32((p00 * (64'sd1 <<< 30)) / s);
      k1 = clip32((p10 * (64'sd1 <<< 30)) / s);
    end
    t00 = p00;
    t01 = p01;
    cov[0] = clip32(p00 - mul_rnd(k0, t00, 30));
    cov[1] = clip32(p01 - mul_rnd(k0, t01, 30));
    cov[2] = clip32(p10 - mul_rnd(k1, t00, 30));
    cov[3] = clip32(p11 - mul_rnd(k1, t01, 30));

    for (a = 0; a < 3; a++) begin
      innov = meas[a] - angle_est[a];
      angle_est[a] = clip32(angle_est[a] + mul_rnd(k0, innov, 30));
      bias_est[a] = clip32(bias_est[a] + mul_rnd(k1, innov, 30));
    end
    for (a = 0; a < 3; a++) begin
      res[a] = angle_est[a][31:0];
      res[3 + a] = bias_est[a][31:0];
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = attitude_q.size();

  always @(posedge clk) begin
    longint rate[3], acc[3];
    attitude_t res, got;
    int f;
    if (rst) begin
      for (f = 0; f < 3; f++) begin
        angle_est[f] = 0;
        bias_est[f] = 0;
      end
      for (f = 0; f < 4; f++) cov[f] = 0;
      noise_qa = QA_RESET;
      noise_qb = QB_RESET;
      noise_r  = R_RESET;
      dt_q30   = DT_RESET;
      attitude_q.delete();
    end else begin
      // register writes; unknown indexes are ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_QA:  noise_qa = cfg_data;
          REG_QB:  noise_qb = cfg_data;
          REG_R:   noise_r  = cfg_data;
          REG_DT:  dt_q30   = cfg_data;
          default: ;
        endcase
      end
      // sample transfer
      if (in_valid && !in_stall) begin
        rate = '{rate_x, rate_y, rate_z};
        acc  = '{acc_x, acc_y, acc_z};
        predict_attitude(rate, acc, res);
        attitude_q.push_back(res);
      end
      // result transfer
      if (out_valid && !out_stall) begin
        got = {bias_z_out, bias_y_out, bias_x_out, yaw_out, pitch_out, roll_out};
        if (attitude_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          res = attitude_q.pop_front();
          for (f = 0; f < 6; f++)
            if (got[f] !== res[f]) report(field_name[f], got[f], res[f]);
        end
      end
    end
  end

endmodule

[tb/sv/imu_kalman_orientation_core_tb.sv]
// Top of the imu_kalman_orientation_core testbench: clock, reset, register phases,
// sample stimulus and result stalls. Depends on ikf_pkg and the checker module.
`timescale 1ns / 1ps

module imu_kalman_orientation_core_tb
  import ikf_pkg::*;
();

  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 320;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic signed [31:0] rate_x = '0, rate_y = '0, rate_z = '0;
  logic signed [31:0] acc_x = '0, acc_y = '0, acc_z = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [31:0] roll_out, pitch_out, yaw_out, bias_x_out, bias_y_out, bias_z_out;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [29:0] cfg_data = '0;
  int errors, pending;
  int cycles = 0;

  imu_kalman_orientation_core dut (.*);

  imu_kalman_orientation_checker checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: one long hold-off once random traffic runs, then shifting stall patterns
  initial begin
    int mode;
    @(negedge rst);
    repeat (8000) @(negedge clk);
    out_stall = 1'b1;
    repeat (1500) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      repeat (64) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          default: out_stall = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // register write; only issued while the block is idle
  task automatic write_reg(input logic [2:0] idx, input logic [29:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // one sample transfer; valid stays high into the next sample unless a gap follows
  task automatic send_sample(input logic [31:0] rx, ry, rz, ax, ay, az, input int gap);
    @(negedge clk);
    in_valid = 1'b1;
    {rate_x, rate_y, rate_z} = {rx, ry, rz};
    {acc_x, acc_y, acc_z} = {ax, ay, az};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value(input bit is_rate);
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 6)
      return is_rate ? 32'($signed($urandom_range(0, 65536000)) - 32768000)
                     : 32'($signed($urandom_range(0, 262144)) - 131072);
    if (kind < 9) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  task automatic random_burst_run(input int n);
    int burst, gap;
    burst = 0;
    repeat (n) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap = 0;
      end
      burst--;
      gap = (burst == 0) ? $urandom_range(1, 8) : 0;
      send_sample(pick_value(1), pick_value(1), pick_value(1),
                  pick_value(0), pick_value(0), pick_value(0), gap);
    end
  endtask

  initial begin
    int p;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero noise and zero covariance: first step hits the degenerate gain
    write_reg(REG_QA, 30'd0);
    write_reg(REG_R, 30'd0);
    send_sample(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0);
    send_sample(32'h10000, 32'h0, 32'hffff0000, 32'h0, 32'h0, 32'h10000, 2);
    drain();

    // defaults back; zero vector, left half plane, both signs of y
    write_reg(REG_QA, QA_RESET);
    write_reg(REG_R, R_RESET);
    send_sample(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0);
    send_sample(32'h0, 32'h0, 32'h0, 32'hffff0000, 32'h8000, 32'h0, 0);
    send_sample(32'h0, 32'h0, 32'h0, 32'hffff0000, 32'hffff8000, 32'h0, 1);
    send_sample(32'h0, 32'h0, 32'h0, 32'hffff0000, 32'h0, 32'h0, 0);
    send_sample(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    send_sample(32'h80000000, 32'h7fffffff, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h80000000, 3);
    send_sample(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hfff00000, 0);
    drain();

    // zero time step, unused register index, then extreme settings
    write_reg(REG_DT, 30'd0);
    write_reg(REG_UNUSED, 30'h3fffffff);
    send_sample(32'h00640000, 32'hff9c0000, 32'h1, 32'h10000, 32'h20000, 32'h30000, 0);
    send_sample(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h10000, 32'h0, 1);
    drain();
    write_reg(REG_DT, 30'h3fffffff);
    write_reg(REG_QA, 30'h3fffffff);
    write_reg(REG_QB, 30'h3fffffff);
    write_reg(REG_R, 30'h3fffffff);
    repeat (4) send_sample(32'h7fffffff, 32'h80000000, 32'h00010000,
                           32'h00008000, 32'hffff0000, 32'h7fff0000, 0);
    send_sample(32'h80000000, 32'h80000000, 32'h80000000, 32'h1, 32'h1, 32'h1, 1);
    drain();

    // random phases, each under its own register setting
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(REG_QA, QA_RESET); write_reg(REG_QB, QB_RESET);
          write_reg(REG_R, R_RESET);   write_reg(REG_DT, DT_RESET);
        end
        1: begin
          write_reg(REG_QA, 30'd0); write_reg(REG_QB, 30'd0);
          write_reg(REG_R, 30'd1);  write_reg(REG_DT, 30'd1);
        end
        2: begin
          write_reg(REG_QA, 30'h3fffffff); write_reg(REG_R, 30'd0);
          write_reg(REG_DT, 30'h3fffffff);
        end
        default: begin
          write_reg(REG_QA, 30'($urandom)); write_reg(REG_QB, 30'($urandom));
          write_reg(REG_R, 30'($urandom));
          write_reg(REG_DT, ($urandom_range(0, 1) == 1) ? 30'($urandom_range(1, 50000000))
                                                        : 30'($urandom));
        end
      endcase
      random_burst_run(305);
      drain();
    end

    // wait out any late activity, then the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
